// ----- hw/rtl/image_header_size_sniffer_defines.svh -----
// Assertion macros used by the image header size sniffer top module.
`ifndef IMAGE_HEADER_SIZE_SNIFFER_DEFINES_SVH
`define IMAGE_HEADER_SIZE_SNIFFER_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define HSS_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("invariant violated");
// Checks that a condition in one cycle implies another in the next cycle.
`define HSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check violated");
`else
`define HSS_ASSERT_ALWAYS(label, clk, rstn, expr)
`define HSS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/hss_pkg.sv -----
// Types and constants of the image header size sniffer.
`default_nettype none
package hss_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [2:0]  image_format;
        logic [30:0] image_width;
        logic [30:0] image_height;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_FRAME,
        PH_SKIP,
        PH_DONE
    } jpeg_phase_t;

    typedef enum logic [1:0] {
        V_UNDECIDED,
        V_FAIL,
        V_OK
    } verdict_t;

    // JPEG walk outcome as seen after the current byte.
    typedef struct packed {
        logic        ok;
        logic [15:0] width;
        logic [15:0] height;
    } jpeg_res_t;

    // Stream length thresholds after the current byte.
    typedef struct packed {
        logic ge4;
        logic ge10;
        logic ge24;
        logic ge30;
    } len_flags_t;

    localparam int HDR_DEPTH = 30;

    localparam logic [2:0] FMT_NONE = 3'd0;
    localparam logic [2:0] FMT_PNG  = 3'd1;
    localparam logic [2:0] FMT_GIF  = 3'd2;
    localparam logic [2:0] FMT_JPEG = 3'd3;
    localparam logic [2:0] FMT_WEBP = 3'd4;

    localparam logic [7:0] MK_FILL = 8'hFF;
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_DHT  = 8'hC4;
    localparam logic [7:0] MK_JPG  = 8'hC8;
    localparam logic [7:0] MK_DAC  = 8'hCC;

    localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                           8'h0D, 8'h0A, 8'h1A, 8'h0A};

endpackage
`default_nettype wire

// ----- hw/rtl/image_header_size_sniffer.sv -----
// Image header size sniffer: reads the start of a file and reports its dimensions.
//
// Usage: file bytes enter on the s_ channel, one per transfer, with last_byte set
// on the final byte of a stream. Each stream yields exactly one result on the
// m_ channel: found, format (PNG, GIF, JPEG or WebP) and the width and height.
// Only the first MAX_LEN bytes of a stream are examined; later bytes are dropped,
// but their last_byte flag still closes the stream.
// Path: the final byte passes the input register and one decode stage, which
// loads the output register that drives the m_ channel.
// Throughput: one byte per cycle unless a final byte waits on a pending result;
// one decode stage feeds the offset counter, 30-byte header store and JPEG walker.
// Reset: aresetn clears all control state; the header store is not cleared,
// since only bytes of the current stream are ever read.
// Stall: while a result waits on m_ready, ordinary bytes keep flowing; only a
// second final byte waits in the input register, and then s_ready drops.
`default_nettype none
module image_header_size_sniffer #(
    parameter int MAX_LEN = 65536
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output      logic              s_ready,
    input  wire hss_pkg::in_item_t s_data,
    output      logic              m_valid,
    input  wire logic              m_ready,
    output hss_pkg::out_item_t     m_data
);
    import hss_pkg::*;

    `include "image_header_size_sniffer_defines.svh"

    localparam int OW = $clog2(MAX_LEN + 1);

    logic             in_valid_reg;
    in_item_t         in_data_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    logic [OW-1:0]    offset_reg;
    logic [OW-1:0]    len_next;
    logic [29:0][7:0] hdr_reg;
    logic [29:0][7:0] hb_view;
    logic             advance, in_range, step_en, feed_en;
    len_flags_t       len;
    jpeg_res_t        jpeg;
    out_item_t        result;

    // Handshake: a byte moves on unless it closes a stream while a result waits.
    assign advance = in_valid_reg && (!in_data_reg.last_byte || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Stream offset, saturating at MAX_LEN.
    assign in_range = offset_reg < OW'(MAX_LEN);
    assign step_en  = advance && in_range;
    assign feed_en  = step_en && offset_reg >= OW'(2);
    assign len_next = in_range ? offset_reg + OW'(1) : offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (advance) begin
            offset_reg <= in_data_reg.last_byte ? '0 : len_next;
        end
    end

    // Header store of the first bytes, with the current byte merged in.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < HDR_DEPTH; i++) begin
            if (step_en && offset_reg == OW'(i)) begin
                hdr_reg[i] <= in_data_reg.data_byte;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < HDR_DEPTH; i++) begin
            hb_view[i] = (step_en && offset_reg == OW'(i)) ? in_data_reg.data_byte
                                                          : hdr_reg[i];
        end
    end

    assign len.ge4  = len_next >= OW'(4);
    assign len.ge10 = len_next >= OW'(10);
    assign len.ge24 = len_next >= OW'(24);
    assign len.ge30 = len_next >= OW'(30);

    hss_jpeg_walker u_jpeg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .feed_en   (feed_en),
        .restart   (in_data_reg.last_byte),
        .data_byte (in_data_reg.data_byte),
        .res       (jpeg)
    );

    hss_header_decode u_decode (
        .hb     (hb_view),
        .len    (len),
        .jpeg   (jpeg),
        .result (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_data_reg.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_data_reg.last_byte) begin
            m_data_reg <= result;
        end
    end

    `HSS_ASSERT_ALWAYS(a_offset_bound, aclk, aresetn, offset_reg <= OW'(MAX_LEN))
    `HSS_ASSERT_NEXT(a_offset_restart, aclk, aresetn, advance && in_data_reg.last_byte, offset_reg == '0)
    `HSS_ASSERT_ALWAYS(a_stall_cause, aclk, aresetn, s_ready || (in_valid_reg && m_valid_reg && !m_ready))
    `HSS_ASSERT_ALWAYS(a_found_dims, aclk, aresetn, !(m_valid_reg && m_data_reg.found) || (m_data_reg.image_width != '0 && m_data_reg.image_height != '0))

endmodule
`default_nettype wire

// ----- hw/rtl/hss_jpeg_walker.sv -----
// JPEG marker segment walker, one byte per step.
`default_nettype none
module hss_jpeg_walker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step_en,
    input  wire logic              feed_en,
    input  wire logic              restart,
    input  wire logic [7:0]        data_byte,
    output hss_pkg::jpeg_res_t     res
);
    import hss_pkg::*;

    jpeg_phase_t phase_reg, phase_next;
    verdict_t    verdict_reg, verdict_next;
    logic [7:0]  marker_reg, marker_next;
    logic [15:0] remain_reg, remain_next;
    logic [15:0] fw_reg, fw_next, fh_reg, fh_next;
    logic [15:0] seglen, rem_dec;
    logic        is_sof;

    // Phase register and walker state.
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && restart)) begin
            phase_reg   <= PH_PREFIX;
            verdict_reg <= V_UNDECIDED;
            marker_reg  <= '0;
            remain_reg  <= '0;
            fw_reg      <= '0;
            fh_reg      <= '0;
        end else if (feed_en) begin
            phase_reg   <= phase_next;
            verdict_reg <= verdict_next;
            marker_reg  <= marker_next;
            remain_reg  <= remain_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
        end
    end

    assign seglen  = {remain_reg[15:8], data_byte};
    assign rem_dec = remain_reg - 16'd1;
    assign is_sof  = (marker_reg[7:4] == 4'hC) && (marker_reg != MK_DHT)
                     && (marker_reg != MK_JPG) && (marker_reg != MK_DAC);

    // Next state for one byte of the walk.
    always_comb begin
        phase_next   = phase_reg;
        verdict_next = verdict_reg;
        marker_next  = marker_reg;
        remain_next  = remain_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        if (feed_en) begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    if (data_byte != MK_FILL) begin
                        verdict_next = V_FAIL;
                        phase_next   = PH_DONE;
                    end else begin
                        phase_next = PH_MARKER;
                    end
                end
                PH_MARKER: begin
                    if (data_byte == MK_FILL) begin
                        phase_next = PH_MARKER;
                    end else if (data_byte == MK_SOI || data_byte == MK_TEM
                                 || data_byte[7:3] == 5'b11010) begin
                        phase_next = PH_PREFIX;
                    end else if (data_byte == MK_EOI || data_byte == MK_SOS) begin
                        verdict_next = V_FAIL;
                        phase_next   = PH_DONE;
                    end else begin
                        marker_next = data_byte;
                        phase_next  = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    remain_next = {data_byte, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (seglen < 16'd2) begin
                        verdict_next = V_FAIL;
                        phase_next   = PH_DONE;
                    end else if (is_sof) begin
                        remain_next = 16'd5;
                        phase_next  = PH_FRAME;
                    end else begin
                        remain_next = seglen - 16'd2;
                        phase_next  = (seglen != 16'd2) ? PH_SKIP : PH_PREFIX;
                    end
                end
                PH_FRAME: begin
                    case (remain_reg)
                        16'd4:   fh_next = {data_byte, 8'h00};
                        16'd3:   fh_next = {fh_reg[15:8], data_byte};
                        16'd2:   fw_next = {data_byte, 8'h00};
                        16'd1:   fw_next = {fw_reg[15:8], data_byte};
                        default: ;
                    endcase
                    remain_next = rem_dec;
                    if (rem_dec == 16'd0) begin
                        phase_next   = PH_DONE;
                        verdict_next = (fw_next != 16'd0 && fh_next != 16'd0) ? V_OK : V_FAIL;
                    end
                end
                PH_SKIP: begin
                    remain_next = rem_dec;
                    if (rem_dec == 16'd0) begin
                        phase_next = PH_PREFIX;
                    end
                end
                default: ;
            endcase
        end
    end

    assign res.ok     = (verdict_next == V_OK);
    assign res.width  = fw_next;
    assign res.height = fh_next;

endmodule
`default_nettype wire

// ----- hw/rtl/hss_header_decode.sv -----
// Format recognition and size extraction from the first header bytes.
`default_nettype none
module hss_header_decode (
    input  wire logic [29:0][7:0]  hb,
    input  wire hss_pkg::len_flags_t len,
    input  wire hss_pkg::jpeg_res_t  jpeg,
    output hss_pkg::out_item_t       result
);
    import hss_pkg::*;

    logic        png_sig_ok, png_ok, gif_ok, jpeg_sel, webp_sel;
    logic        vp8_ok, vp8l_ok, vp8x_ok;
    logic [31:0] png_w, png_h;
    logic [15:0] gif_w, gif_h;
    logic [13:0] vp8_w, vp8_h;
    logic [14:0] vp8l_w, vp8l_h;
    logic [24:0] vp8x_w, vp8x_h;

    // Signature compares.
    always_comb begin
        png_sig_ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (hb[i] != PNG_SIG[i]) begin
                png_sig_ok = 1'b0;
            end
        end
    end

    assign png_ok = len.ge24 && png_sig_ok && hb[12] == 8'h49 && hb[13] == 8'h48
                    && hb[14] == 8'h44 && hb[15] == 8'h52;
    assign gif_ok = len.ge10 && hb[0] == 8'h47 && hb[1] == 8'h49 && hb[2] == 8'h46
                    && hb[3] == 8'h38 && (hb[4] == 8'h37 || hb[4] == 8'h39)
                    && hb[5] == 8'h61;
    assign jpeg_sel = len.ge4 && hb[0] == 8'hFF && hb[1] == 8'hD8 && hb[2] == 8'hFF;
    assign webp_sel = len.ge30 && hb[0] == 8'h52 && hb[1] == 8'h49 && hb[2] == 8'h46
                      && hb[3] == 8'h46 && hb[8] == 8'h57 && hb[9] == 8'h45
                      && hb[10] == 8'h42 && hb[11] == 8'h50;
    assign vp8_ok  = hb[12] == 8'h56 && hb[13] == 8'h50 && hb[14] == 8'h38
                     && hb[15] == 8'h20 && hb[23] == 8'h9D && hb[24] == 8'h01
                     && hb[25] == 8'h2A;
    assign vp8l_ok = hb[12] == 8'h56 && hb[13] == 8'h50 && hb[14] == 8'h38
                     && hb[15] == 8'h4C && hb[20] == 8'h2F;
    assign vp8x_ok = hb[12] == 8'h56 && hb[13] == 8'h50 && hb[14] == 8'h38
                     && hb[15] == 8'h58;

    // Field extraction for each format.
    assign png_w  = {hb[16], hb[17], hb[18], hb[19]};
    assign png_h  = {hb[20], hb[21], hb[22], hb[23]};
    assign gif_w  = {hb[7], hb[6]};
    assign gif_h  = {hb[9], hb[8]};
    assign vp8_w  = {hb[27][5:0], hb[26]};
    assign vp8_h  = {hb[29][5:0], hb[28]};
    assign vp8l_w = {1'b0, hb[22][5:0], hb[21]} + 15'd1;
    assign vp8l_h = {1'b0, hb[24][3:0], hb[23], hb[22][7:6]} + 15'd1;
    assign vp8x_w = {1'b0, hb[26], hb[25], hb[24]} + 25'd1;
    assign vp8x_h = {1'b0, hb[29], hb[28], hb[27]} + 25'd1;

    // Priority selection in the order PNG, GIF, JPEG, WebP.
    always_comb begin
        result = '0;
        if (png_ok) begin
            if (png_w != 32'd0 && png_h != 32'd0
                && png_w < 32'h7FFF_FFFF && png_h < 32'h7FFF_FFFF) begin
                result.found        = 1'b1;
                result.image_format = FMT_PNG;
                result.image_width  = png_w[30:0];
                result.image_height = png_h[30:0];
            end
        end else if (gif_ok) begin
            if (gif_w != 16'd0 && gif_h != 16'd0) begin
                result.found        = 1'b1;
                result.image_format = FMT_GIF;
                result.image_width  = {15'd0, gif_w};
                result.image_height = {15'd0, gif_h};
            end
        end else if (jpeg_sel) begin
            if (jpeg.ok) begin
                result.found        = 1'b1;
                result.image_format = FMT_JPEG;
                result.image_width  = {15'd0, jpeg.width};
                result.image_height = {15'd0, jpeg.height};
            end
        end else if (webp_sel) begin
            if (vp8_ok) begin
                if (vp8_w != 14'd0 && vp8_h != 14'd0) begin
                    result.found        = 1'b1;
                    result.image_format = FMT_WEBP;
                    result.image_width  = {17'd0, vp8_w};
                    result.image_height = {17'd0, vp8_h};
                end
            end else if (vp8l_ok) begin
                result.found        = 1'b1;
                result.image_format = FMT_WEBP;
                result.image_width  = {16'd0, vp8l_w};
                result.image_height = {16'd0, vp8l_h};
            end else if (vp8x_ok) begin
                result.found        = 1'b1;
                result.image_format = FMT_WEBP;
                result.image_width  = {6'd0, vp8x_w};
                result.image_height = {6'd0, vp8x_h};
            end
        end
        if (!result.found) begin
            result.image_format = FMT_NONE;
        end
    end

endmodule
`default_nettype wire
